### rtl/apt_pkg.sv
`default_nettype none
package apt_pkg;

    localparam int unsigned CFG_AW = 5;
    localparam int unsigned CFG_DW = 32;

    localparam logic [2:0] REG_TARGET   = 3'd0;
    localparam logic [2:0] REG_KP_UP    = 3'd1;
    localparam logic [2:0] REG_KD_UP    = 3'd2;
    localparam logic [2:0] REG_KP_DOWN  = 3'd3;
    localparam logic [2:0] REG_KD_DOWN  = 3'd4;
    localparam logic [2:0] REG_KI_DT    = 3'd5;
    localparam logic [2:0] REG_BASE     = 3'd6;
    localparam logic [2:0] REG_INT_LIM  = 3'd7;

    localparam logic signed [16:0] RST_TARGET  = 17'sd1408;
    localparam logic [15:0]         RST_KP_UP   = 16'd2560;
    localparam logic [15:0]         RST_KD_UP   = 16'd486;
    localparam logic [15:0]         RST_KP_DOWN = 16'd2688;
    localparam logic [15:0]         RST_KD_DOWN = 16'd563;
    localparam logic [15:0]         RST_KI_DT   = 16'd492;
    localparam logic [10:0]         RST_BASE    = 11'd410;
    localparam logic [22:0]         RST_INT_LIM = 23'd2560000;

    typedef struct packed {
        logic signed [16:0] setpoint;
        logic [15:0]        kp_up_gain;
        logic [15:0]        kd_up_gain;
        logic [15:0]        kp_down_gain;
        logic [15:0]        kd_down_gain;
        logic [15:0]        ki_dt_gain;
        logic [10:0]        thr_base;
        logic [22:0]        isum_limit;
    } t_cfg;

endpackage
`default_nettype wire

### rtl/apt_in_if.sv
`default_nettype none
interface apt_in_if;
    logic               valid;
    logic               ready;
    logic signed [16:0] angle;
    logic signed [19:0] gyro_rate;

    modport source (output valid, output angle, output gyro_rate, input ready);
    modport sink (input valid, input angle, input gyro_rate, output ready);
endinterface
`default_nettype wire

### rtl/apt_out_if.sv
`default_nettype none
interface apt_out_if;
    logic               valid;
    logic               ready;
    logic [10:0]        throttle;
    logic signed [17:0] angle_error;
    logic signed [23:0] correction;
    logic signed [23:0] integral_term;

    modport source (output valid, output throttle, output angle_error,
                    output correction, output integral_term, input ready);
    modport sink (input valid, input throttle, input angle_error,
                  input correction, input integral_term, output ready);
endinterface
`default_nettype wire

### rtl/apt_cfg.sv
`default_nettype none
module apt_cfg
    import apt_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [CFG_AW-1:0] paddr,
    input  wire logic [CFG_DW-1:0] pwdata,
    output logic      [CFG_DW-1:0] prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    t_cfg       r_cfg;
    logic       c_wr;
    logic [2:0] c_idx;

    assign pready = 1'b1;
    assign c_wr   = psel & penable & pwrite;
    assign c_idx  = paddr[4:2];
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.setpoint     <= RST_TARGET;
            r_cfg.kp_up_gain   <= RST_KP_UP;
            r_cfg.kd_up_gain   <= RST_KD_UP;
            r_cfg.kp_down_gain <= RST_KP_DOWN;
            r_cfg.kd_down_gain <= RST_KD_DOWN;
            r_cfg.ki_dt_gain   <= RST_KI_DT;
            r_cfg.thr_base     <= RST_BASE;
            r_cfg.isum_limit   <= RST_INT_LIM;
        end else if (c_wr) begin
            unique case (c_idx)
                REG_TARGET:  r_cfg.setpoint     <= $signed(pwdata[16:0]);
                REG_KP_UP:   r_cfg.kp_up_gain   <= pwdata[15:0];
                REG_KD_UP:   r_cfg.kd_up_gain   <= pwdata[15:0];
                REG_KP_DOWN: r_cfg.kp_down_gain <= pwdata[15:0];
                REG_KD_DOWN: r_cfg.kd_down_gain <= pwdata[15:0];
                REG_KI_DT:   r_cfg.ki_dt_gain   <= pwdata[15:0];
                REG_BASE:    r_cfg.thr_base     <= pwdata[10:0];
                REG_INT_LIM: r_cfg.isum_limit   <= pwdata[22:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (c_idx)
            REG_TARGET:  prdata = CFG_DW'(r_cfg.setpoint);
            REG_KP_UP:   prdata = {16'd0, r_cfg.kp_up_gain};
            REG_KD_UP:   prdata = {16'd0, r_cfg.kd_up_gain};
            REG_KP_DOWN: prdata = {16'd0, r_cfg.kp_down_gain};
            REG_KD_DOWN: prdata = {16'd0, r_cfg.kd_down_gain};
            REG_KI_DT:   prdata = {16'd0, r_cfg.ki_dt_gain};
            REG_BASE:    prdata = {21'd0, r_cfg.thr_base};
            REG_INT_LIM: prdata = {9'd0, r_cfg.isum_limit};
            default:     prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

### rtl/asymmetric_pid_throttle_top.sv
// Asymmetric PID throttle controller.
// Input channel i_in carries one control tick per transaction: measured angle
// and filtered gyro rate, signed Q8.8 and Q11.8. Output channel o_out returns one
// transaction per input: throttle, angle error, correction and integral term.
// Gains, setpoint, base throttle and integral limit sit behind the APB port
// (register i at byte address 4*i); write them only while the block is idle.
// Pipeline: input register, product stage, integral product stage, output
// register. Throughput is one transaction per cycle while o_out does not stall;
// the error-sum update closes in the product stage, so consecutive ticks need
// no spacing.
// When o_out.ready is low the output register holds and the stages behind it
// fill; i_in.ready drops only once every stage holds a transaction.
// Reset (synchronous, active low) empties the pipeline, clears the error sum
// and loads the default register values.
`default_nettype none
module asymmetric_pid_throttle_top
    import apt_pkg::*;
#(
    parameter int THR_FLOOR       = 100,
    parameter int THR_CEIL        = 650,
    parameter int INTEGRAL_WINDOW = 2048
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    apt_in_if.sink                 i_in,
    apt_out_if.source              o_out,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [CFG_AW-1:0] paddr,
    input  wire logic [CFG_DW-1:0] pwdata,
    output logic      [CFG_DW-1:0] prdata,
    output logic                   pready
);

    localparam logic [17:0]        LP_WIN = 18'(INTEGRAL_WINDOW);
    localparam logic signed [18:0] LP_MAX = 19'(THR_CEIL);
    localparam logic signed [18:0] LP_MIN = 19'(THR_FLOOR);

    t_cfg c_cfg;

    apt_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (c_cfg)
    );

    logic r_v0, r_v1, r_v2, r_vo;
    logic c_en0, c_en1, c_en2, c_eno;

    logic signed [16:0] r_s0_angle;
    logic signed [19:0] r_s0_gyro;

    logic signed [17:0] r_s1_err;
    logic signed [33:0] r_s1_pprod;
    logic signed [36:0] r_s1_dprod;
    logic signed [23:0] r_s1_sum;
    logic signed [23:0] r_err_sum;
    logic signed [23:0] n_err_sum;

    logic signed [17:0] r_s2_err;
    logic signed [25:0] r_s2_p;
    logic signed [28:0] r_s2_d;
    logic signed [40:0] r_s2_iprod;

    logic [10:0]        r_o_thr;
    logic signed [17:0] r_o_err;
    logic signed [23:0] r_o_corr;
    logic signed [23:0] r_o_iterm;

    assign c_eno = !r_vo || o_out.ready;
    assign c_en2 = !r_v2 || c_eno;
    assign c_en1 = !r_v1 || c_en2;
    assign c_en0 = !r_v0 || c_en1;
    assign i_in.ready = c_en0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0      <= 1'b0;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_vo      <= 1'b0;
            r_err_sum <= '0;
        end else begin
            if (c_en0) r_v0 <= i_in.valid;
            if (c_en1) r_v1 <= r_v0;
            if (c_en2) r_v2 <= r_v1;
            if (c_eno) r_vo <= r_v2;
            if (c_en1 && r_v0) r_err_sum <= n_err_sum;
        end
    end

    // stage 1: error, gain select, P/D products, error-sum update
    logic signed [17:0] c_err;
    logic [17:0]        c_mag;
    logic [15:0]        c_kp, c_kd;
    logic signed [33:0] c_pprod;
    logic signed [36:0] c_dprod;
    logic signed [24:0] c_sum_raw, c_lim;

    always_comb begin
        c_err   = 18'(c_cfg.setpoint) - 18'(r_s0_angle);
        c_mag   = c_err[17] ? 18'(-c_err) : 18'(c_err);
        c_kp    = c_err[17] ? c_cfg.kp_down_gain : c_cfg.kp_up_gain;
        c_kd    = c_err[17] ? c_cfg.kd_down_gain : c_cfg.kd_up_gain;
        c_pprod = 34'($signed({1'b0, c_kp})) * 34'(c_err);
        c_dprod = 37'($signed({1'b0, c_kd})) * 37'(r_s0_gyro);
        c_lim   = $signed({2'b00, c_cfg.isum_limit});
        c_sum_raw = (c_mag < LP_WIN) ? (25'(r_err_sum) + 25'(c_err)) : '0;
        if (c_sum_raw > c_lim) begin
            n_err_sum = 24'(c_lim);
        end else if (c_sum_raw < -c_lim) begin
            n_err_sum = 24'(-c_lim);
        end else begin
            n_err_sum = 24'(c_sum_raw);
        end
    end

    // stage 2: round P and D, integral product
    logic signed [33:0] c_pr;
    logic signed [36:0] c_dr;
    always_comb begin
        c_pr = (r_s1_pprod + 34'sd128) >>> 8;
        c_dr = (-r_s1_dprod + 37'sd128) >>> 8;
    end

    // stage 3: integral rounding, correction sum, throttle clamp
    logic signed [40:0] c_ir;
    logic signed [23:0] c_iterm;
    logic signed [30:0] c_csum;
    logic signed [23:0] c_corr;
    logic signed [25:0] c_tsum;
    logic signed [18:0] c_thr;
    logic signed [18:0] c_thr_hi;
    logic [10:0]        c_thr_out;

    always_comb begin
        c_ir = (r_s2_iprod + 41'sd32768) >>> 16;
        if (c_ir > 41'sd8388607) begin
            c_iterm = 24'sh7FFFFF;
        end else if (c_ir < -41'sd8388608) begin
            c_iterm = 24'sh800000;
        end else begin
            c_iterm = 24'(c_ir);
        end
        c_csum = 31'(r_s2_p) + 31'(r_s2_d) + 31'(c_iterm);
        if (c_csum > 31'sd8388607) begin
            c_corr = 24'sh7FFFFF;
        end else if (c_csum < -31'sd8388608) begin
            c_corr = 24'sh800000;
        end else begin
            c_corr = 24'(c_csum);
        end
        c_tsum   = $signed({7'd0, c_cfg.thr_base, 8'd0}) + 26'(c_corr);
        c_thr    = 19'(c_tsum >>> 8);
        c_thr_hi = (c_thr > LP_MAX) ? LP_MAX : c_thr;
        c_thr_out = (c_thr_hi < LP_MIN) ? LP_MIN[10:0] : c_thr_hi[10:0];
    end

    always_ff @(posedge i_clk) begin
        if (c_en0) begin
            r_s0_angle <= i_in.angle;
            r_s0_gyro  <= i_in.gyro_rate;
        end
        if (c_en1) begin
            r_s1_err   <= c_err;
            r_s1_pprod <= c_pprod;
            r_s1_dprod <= c_dprod;
            r_s1_sum   <= n_err_sum;
        end
        if (c_en2) begin
            r_s2_err   <= r_s1_err;
            r_s2_p     <= 26'(c_pr);
            r_s2_d     <= 29'(c_dr);
            r_s2_iprod <= 41'($signed({1'b0, c_cfg.ki_dt_gain})) * 41'(r_s1_sum);
        end
        if (c_eno) begin
            r_o_thr   <= c_thr_out;
            r_o_err   <= r_s2_err;
            r_o_corr  <= c_corr;
            r_o_iterm <= c_iterm;
        end
    end

    assign o_out.valid         = r_vo;
    assign o_out.throttle      = r_o_thr;
    assign o_out.angle_error   = r_o_err;
    assign o_out.correction    = r_o_corr;
    assign o_out.integral_term = r_o_iterm;

endmodule
`default_nettype wire

### test/tb_asymmetric_pid_throttle_top.sv
module tb_asymmetric_pid_throttle_top
    import apt_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MIN_THR = 100;
    localparam int MAX_THR = 650;
    localparam int WINDOW  = 2048;
    localparam int LATENCY = 3;
    localparam longint SAT_MAX = 64'sd8388607;
    localparam longint SAT_MIN = -64'sd8388608;

    typedef struct {
        logic [10:0]        throttle;
        logic signed [17:0] angle_error;
        logic signed [23:0] correction;
        logic signed [23:0] integral_term;
    } t_tick_result;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [CFG_AW-1:0]  paddr;
    logic [CFG_DW-1:0]  pwdata;
    wire  [CFG_DW-1:0]  prdata;
    wire                pready;

    apt_in_if  tick_if ();
    apt_out_if result_if ();

    asymmetric_pid_throttle_top #(
        .THR_FLOOR(MIN_THR),
        .THR_CEIL(MAX_THR),
        .INTEGRAL_WINDOW(WINDOW)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in(tick_if),
        .o_out(result_if),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    t_cfg         model_cfg;
    longint       model_err_sum;
    t_tick_result pending_results[$];
    int           fail_count;
    bit           gaps_on;
    int           long_hold;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic longint sat(longint v, longint lo, longint hi);
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // Mirrors the controller for one tick; updates the error sum.
    function automatic t_tick_result predict_tick(logic signed [16:0] angle,
                                                  logic signed [19:0] gyro);
        t_tick_result r;
        longint err, kp, kd, p, d, iterm, corr, thr, mag, lim;
        err = longint'($signed(model_cfg.setpoint)) - longint'(angle);
        if (err < 0) begin
            kp = longint'(model_cfg.kp_down_gain);
            kd = longint'(model_cfg.kd_down_gain);
        end else begin
            kp = longint'(model_cfg.kp_up_gain);
            kd = longint'(model_cfg.kd_up_gain);
        end
        p = (kp * err + 128) >>> 8;
        d = (-(kd * longint'(gyro)) + 128) >>> 8;
        mag = (err < 0) ? -err : err;
        model_err_sum = (mag < WINDOW) ? model_err_sum + err : 0;
        lim = longint'(model_cfg.isum_limit);
        model_err_sum = sat(model_err_sum, -lim, lim);
        iterm = sat((longint'(model_cfg.ki_dt_gain) * model_err_sum + 32768) >>> 16,
                    SAT_MIN, SAT_MAX);
        corr = sat(p + d + iterm, SAT_MIN, SAT_MAX);
        thr = (longint'(model_cfg.thr_base) * 256 + corr) >>> 8;
        if (thr > MAX_THR) thr = MAX_THR;
        if (thr < MIN_THR) thr = MIN_THR;
        r.throttle      = thr[10:0];
        r.angle_error   = err[17:0];
        r.correction    = corr[23:0];
        r.integral_term = iterm[23:0];
        return r;
    endfunction

    task automatic report_error(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        fail_count++;
    endtask

    // Output stall: random short/long holds, plus an explicit long hold.
    initial begin
        int hold;
        hold = 0;
        result_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold > 0) begin
                result_if.ready <= 1'b0;
                long_hold--;
            end else begin
                if (hold == 0) hold = pick_gap();
                if (hold > 0) begin
                    result_if.ready <= 1'b0;
                    hold--;
                end else begin
                    result_if.ready <= 1'b1;
                end
            end
        end
    end

    // Scoreboard: check the output transaction first, then predict the new input.
    always @(posedge i_clk) begin : result_monitor
        t_tick_result want;
        if (i_rst_n) begin
            if (result_if.valid && result_if.ready) begin
                if (pending_results.size() == 0) begin
                    report_error($sformatf("unexpected transaction, throttle %0d",
                                           result_if.throttle));
                end else begin
                    want = pending_results.pop_front();
                    if (result_if.throttle !== want.throttle)
                        report_error($sformatf("throttle got %0d expected %0d",
                                               result_if.throttle, want.throttle));
                    if (result_if.angle_error !== want.angle_error)
                        report_error($sformatf("angle_error got %0d expected %0d",
                                               result_if.angle_error, want.angle_error));
                    if (result_if.correction !== want.correction)
                        report_error($sformatf("correction got %0d expected %0d",
                                               result_if.correction, want.correction));
                    if (result_if.integral_term !== want.integral_term)
                        report_error($sformatf("integral_term got %0d expected %0d",
                                               result_if.integral_term,
                                               want.integral_term));
                end
            end
            if (tick_if.valid && tick_if.ready)
                pending_results.push_back(predict_tick(tick_if.angle, tick_if.gyro_rate));
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_AW'({idx, 2'b00});
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_TARGET:  model_cfg.setpoint     = value[16:0];
            REG_KP_UP:   model_cfg.kp_up_gain   = value[15:0];
            REG_KD_UP:   model_cfg.kd_up_gain   = value[15:0];
            REG_KP_DOWN: model_cfg.kp_down_gain = value[15:0];
            REG_KD_DOWN: model_cfg.kd_down_gain = value[15:0];
            REG_KI_DT:   model_cfg.ki_dt_gain   = value[15:0];
            REG_BASE:    model_cfg.thr_base     = value[10:0];
            REG_INT_LIM: model_cfg.isum_limit   = value[22:0];
            default: ;
        endcase
    endtask

    task automatic send_tick(input logic signed [16:0] angle,
                             input logic signed [19:0] gyro);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            tick_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        tick_if.valid     <= 1'b1;
        tick_if.angle     <= angle;
        tick_if.gyro_rate <= gyro;
        do @(posedge i_clk); while (!tick_if.ready);
    endtask

    // Mostly in-window errors so the error sum builds up; the rest full range.
    task automatic send_random_tick();
        logic signed [16:0] angle;
        logic signed [19:0] gyro;
        if ($urandom_range(0, 9) < 7)
            angle = model_cfg.setpoint - 17'($urandom_range(0, 4094) - 2047);
        else
            angle = 17'($urandom());
        if ($urandom_range(0, 1) == 0)
            gyro = 20'($urandom_range(0, 2000) - 1000);
        else
            gyro = 20'($urandom());
        send_tick(angle, gyro);
    endtask

    task automatic wait_idle();
        tick_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() > 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic write_defaults();
        write_reg(REG_TARGET,  32'(RST_TARGET));
        write_reg(REG_KP_UP,   32'(RST_KP_UP));
        write_reg(REG_KD_UP,   32'(RST_KD_UP));
        write_reg(REG_KP_DOWN, 32'(RST_KP_DOWN));
        write_reg(REG_KD_DOWN, 32'(RST_KD_DOWN));
        write_reg(REG_KI_DT,   32'(RST_KI_DT));
        write_reg(REG_BASE,    32'(RST_BASE));
        write_reg(REG_INT_LIM, 32'(RST_INT_LIM));
    endtask

    task automatic write_all(input logic [31:0] value);
        for (int i = 0; i < 8; i++) write_reg(3'(i), value);
    endtask

    task automatic write_random_config();
        logic [31:0] value;
        for (int i = 0; i < 8; i++) begin
            case ($urandom_range(0, 3))
                0: value = '0;
                1: value = '1;
                2: value = $urandom_range(0, 20000);
                default: value = $urandom();
            endcase
            write_reg(3'(i), value);
        end
    endtask

    task automatic test_reset_directed();
        send_tick(model_cfg.setpoint, 20'sd0);
        send_tick(model_cfg.setpoint + 17'sd1, 20'sd0);
        send_tick(model_cfg.setpoint - 17'sd2047, 20'sd524287);
        send_tick(model_cfg.setpoint + 17'sd2047, -20'sd524288);
        send_tick(model_cfg.setpoint - 17'sd2048, 20'sd0);
        send_tick(model_cfg.setpoint + 17'sd2048, 20'sd1);
        send_tick(-17'sd65536, -20'sd1);
        send_tick(17'sd65535, 20'sd0);
        send_tick(17'sd46080, 20'sd256);
        send_tick(-17'sd46080, -20'sd256);
        wait_idle();
        write_reg(REG_TARGET, 32'(-65536));
        send_tick(17'sd65535, 20'sd0);
        wait_idle();
        write_reg(REG_TARGET, 32'(65535));
        send_tick(-17'sd65536, 20'sd0);
        wait_idle();
    endtask

    task automatic test_integral_clamp();
        write_reg(REG_TARGET, 32'd0);
        write_reg(REG_KI_DT, 32'hFFFF);
        write_reg(REG_INT_LIM, 32'd3000);
        repeat (3) send_tick(-17'sd2047, 20'sd0);
        send_tick(17'sd2047, 20'sd0);
        wait_idle();
        write_reg(REG_INT_LIM, 32'd0);
        send_tick(-17'sd100, 20'sd0);
        wait_idle();
    endtask

    task automatic test_throttle_limits();
        write_reg(REG_BASE, 32'd0);
        send_tick(17'sd10000, 20'sd0);
        send_tick(17'sd0, 20'sd0);
        wait_idle();
        write_reg(REG_BASE, 32'd2047);
        send_tick(-17'sd10000, 20'sd0);
        send_tick(17'sd0, -20'sd4000);
        wait_idle();
    endtask

    task automatic test_output_stall();
        write_defaults();
        gaps_on = 1'b0;
        long_hold = 120;
        repeat (40) send_random_tick();
        wait_idle();
        gaps_on = 1'b1;
    endtask

    task automatic test_random_phases();
        for (int phase = 0; phase < 10; phase++) begin
            case (phase)
                0: write_defaults();
                1: write_all('0);
                2: write_all('1);
                3: write_defaults();
                default: write_random_config();
            endcase
            gaps_on = (phase % 3 != 1);
            repeat (88) send_random_tick();
            wait_idle();
        end
        gaps_on = 1'b1;
    endtask

    initial begin
        i_rst_n           = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        tick_if.valid     = 1'b0;
        tick_if.angle     = '0;
        tick_if.gyro_rate = '0;
        fail_count        = 0;
        gaps_on           = 1'b1;
        long_hold         = 0;
        model_err_sum     = 0;
        model_cfg.setpoint     = RST_TARGET;
        model_cfg.kp_up_gain   = RST_KP_UP;
        model_cfg.kd_up_gain   = RST_KD_UP;
        model_cfg.kp_down_gain = RST_KP_DOWN;
        model_cfg.kd_down_gain = RST_KD_DOWN;
        model_cfg.ki_dt_gain   = RST_KI_DT;
        model_cfg.thr_base     = RST_BASE;
        model_cfg.isum_limit   = RST_INT_LIM;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_directed();
        test_integral_clamp();
        test_throttle_limits();
        test_output_stall();
        test_random_phases();
        wait_idle();

        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
